>>> sv/fvd_pkg.sv
// Shared types and constants of the diffusion flux divergence core.
package fvd_pkg;

   localparam logic [63:0] MAX63       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN64       = 64'h8000_0000_0000_0000;
   localparam logic [62:0] LIGHT_RESET = 63'd1287598802698;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_FACE,
      KIND_REFLECT
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic             last;
      logic [2:0][63:0] offset;
      logic [2:0][63:0] area;
      logic [62:0]      qa;
      logic [62:0]      qb;
      logic [63:0]      energy;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
      logic        err;
   } div_rsp_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] count;
   } queue_status_type;

endpackage

>>> sv/fv_diffusion_flux_divergence_core.sv
// Top level of the finite-volume diffusion flux divergence core.
// A header or reflecting face needs no arithmetic; an interior face takes
// eleven 64-bit products on the shared multiplier plus the 128-step divider.
// After the last face's arithmetic ends, the result is placed in an output register.
// The input queue holds two transactions, so requests are taken while the back end works.
// Synchronous active-high reset clears the queue, cell state and sums; light speed reloads.
module fv_diffusion_flux_divergence_core #(
   parameter int FRAC_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [62:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // offset_x, offset_y, offset_z, area_x, area_y, area_z, quantity_a, quantity_b, energy
   input  logic [575:0] req_tdata,
   // func, has_neighbour
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // divergence
   output logic [63:0]  rsp_tdata,
   // error_flag
   output logic [0:0]   rsp_tuser
);
   import fvd_pkg::*;

   logic             q_pop;
   logic             q_valid;
   item_type         q_item;
   queue_status_type q_status;
   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic             rsp_err;

   fvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_status   (q_status)
   );

   fvd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   fvd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fvd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_err    (rsp_err)
   );

   assign rsp_tuser = rsp_err;

   queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("queue count beyond depth");

   queue_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> q_status.count ==
         $past(q_status.count) + {1'b0, $past(q_status.push)} - {1'b0, $past(q_status.pop)})
      else $error("queue count lost a transaction");

   unit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

endmodule

>>> sv/fvd_front.sv
// Input side: classify request transactions and hold them in a two-entry queue.
module fvd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [575:0]              req_tdata,
   input  logic [1:0]                req_tuser,
   input  logic                      req_tlast,
   input  logic                      q_pop,
   output logic                      q_valid,
   output fvd_pkg::item_type         q_item,
   output fvd_pkg::queue_status_type q_status
);
   import fvd_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   item_in;
   logic       push;
   logic       pop;

   always_comb begin
      if (!req_tuser[0]) begin
         item_in.kind = KIND_HEADER;
      end else if (req_tuser[1]) begin
         item_in.kind = KIND_FACE;
      end else begin
         item_in.kind = KIND_REFLECT;
      end
      item_in.last      = req_tlast;
      item_in.offset[0] = req_tdata[63:0];
      item_in.offset[1] = req_tdata[127:64];
      item_in.offset[2] = req_tdata[191:128];
      item_in.area[0]   = req_tdata[255:192];
      item_in.area[1]   = req_tdata[319:256];
      item_in.area[2]   = req_tdata[383:320];
      item_in.qa        = req_tdata[446:384];
      item_in.qb        = req_tdata[509:447];
      item_in.energy    = req_tdata[573:510];
   end

   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;
   assign q_status   = '{push: push, pop: pop, count: count_ff};

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> sv/fvd_mul.sv
// Unsigned 64 by 64 multiplier built from one 32 by 32 product, summing the four partial products in turn.
module fvd_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  fvd_pkg::mul_req_type mul_req,
   output fvd_pkg::mul_rsp_type mul_rsp
);
   import fvd_pkg::*;

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [127:0] acc_ff;
   logic [1:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  pp;
   logic [1:0]   sh;
   logic [127:0] pp_sh;

   always_comb begin
      pp    = {32'd0, a_ff[32*cnt_ff[1] +: 32]} * {32'd0, b_ff[32*cnt_ff[0] +: 32]};
      sh    = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      pp_sh = {64'd0, pp} << {sh, 5'd0};
   end

   assign mul_rsp = '{done: done_ff, prod: acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            acc_ff  <= '0;
            cnt_ff  <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + pp_sh;
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> sv/fvd_div.sv
// Restoring divider for the negated fixed-point quotient, one bit per cycle.
module fvd_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fvd_pkg::div_req_type div_req,
   output fvd_pkg::div_rsp_type div_rsp
);
   import fvd_pkg::*;

   logic [127:0] dvd_ff;
   logic [63:0]  rem_ff;
   logic [63:0]  q_ff;
   logic [63:0]  den_ff;
   logic [63:0]  quot_ff;
   logic [6:0]   cnt_ff;
   logic         over_ff;
   logic         rneg_ff;
   logic         busy_ff;
   logic         fin_ff;
   logic         done_ff;
   logic         err_ff;
   logic [63:0]  mag;
   logic [63:0]  rem_sh;
   logic         ge;
   logic [63:0]  lim;
   logic         sat;
   logic [63:0]  q_out;

   always_comb begin
      mag    = div_req.num[63] ? (~div_req.num + 64'd1) : div_req.num;
      rem_sh = {rem_ff[62:0], dvd_ff[127]};
      ge     = (rem_sh >= den_ff);
      lim    = rneg_ff ? MIN64 : MAX63;
      sat    = over_ff || (q_ff > lim);
      q_out  = sat ? lim : q_ff;
   end

   assign div_rsp = '{done: done_ff, quot: quot_ff, err: err_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            dvd_ff  <= {64'd0, mag} << FRAC_BITS;
            rem_ff  <= '0;
            q_ff    <= '0;
            den_ff  <= div_req.den;
            over_ff <= 1'b0;
            rneg_ff <= !div_req.num[63];
            cnt_ff  <= 7'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= ge ? (rem_sh - den_ff) : rem_sh;
            q_ff    <= {q_ff[62:0], ge};
            over_ff <= over_ff | q_ff[63];
            dvd_ff  <= {dvd_ff[126:0], 1'b0};
            cnt_ff  <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            quot_ff <= rneg_ff ? (~q_out + 64'd1) : q_out;
            err_ff  <= sat;
            done_ff <= 1'b1;
         end
      end
   end

endmodule

>>> sv/fvd_back.sv
// Execution side: cell state, face arithmetic sequencer and response register.
module fvd_back #(
   parameter int FRAC_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [62:0]          csr_wdata,
   input  logic                 q_valid,
   input  fvd_pkg::item_type    q_item,
   output logic                 q_pop,
   output fvd_pkg::mul_req_type mul_req,
   input  fvd_pkg::mul_rsp_type mul_rsp,
   output fvd_pkg::div_req_type div_req,
   input  fvd_pkg::div_rsp_type div_rsp,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_data,
   output logic                 rsp_err
);
   import fvd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_MUL,
      ST_DIV_ISSUE,
      ST_DIV,
      ST_FINISH,
      ST_EMIT
   } state_type;

   localparam logic [3:0]  LAST_STEP = 4'd10;
   localparam logic [62:0] SIGF_MAX  = 63'(MAX63 / 3);

   function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if ((a[63] == b[63]) && (r[63] != a[63])) begin
         return {1'b1, (a[63] ? MIN64 : MAX63)};
      end
      return {1'b0, r};
   endfunction

   function automatic logic [64:0] ssub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if ((a[63] != b[63]) && (r[63] != a[63])) begin
         return {1'b1, (a[63] ? MIN64 : MAX63)};
      end
      return {1'b0, r};
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   state_type   state_ff;
   item_type    item_ff;
   logic [62:0] cell_cs_ff;
   logic [62:0] cell_vol_ff;
   logic [63:0] cell_en_ff;
   logic [63:0] acc_ff;
   logic        err_seen_ff;
   logic [62:0] light_ff;
   logic [3:0]  step_ff;
   logic        err_ff;
   logic        neg_ff;
   logic [63:0] t_ff;
   logic [63:0] den_ff;
   logic [63:0] adot_ff;
   logic [63:0] num_ff;
   mul_req_type mul_req_ff;
   div_req_type div_req_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_err_ff;

   logic [64:0]            de_res;
   logic [63:0]            op_a;
   logic [63:0]            op_b;
   logic                   op_neg;
   logic [63:0]            prod_mag;
   logic [63-FRAC_BITS:0]  prod_hi;
   logic [63:0]            lim;
   logic                   over;
   logic [63:0]            sat_val;
   logic [63:0]            res;
   logic [63:0]            sum_f;
   logic [62:0]            sig_f;
   logic [64:0]            add_res;
   logic [64:0]            acc_sum;
   logic [63:0]            t_in;
   logic [63:0]            den_in;
   logic [63:0]            adot_in;
   logic [63:0]            num_in;
   logic                   wb_err;

   always_comb begin
      de_res = ssub(item_ff.energy, cell_en_ff);
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      unique case (step_ff)
         4'd0: begin
            op_a = {1'b0, item_ff.qa};
            op_b = {1'b0, item_ff.qb};
         end
         4'd1, 4'd2, 4'd3: begin
            op_a = mag(item_ff.offset[2'(step_ff - 4'd1)]);
            op_b = op_a;
         end
         4'd4: begin
            op_a = den_ff;
            op_b = t_ff;
         end
         4'd5: begin
            op_a = den_ff;
            op_b = {1'b0, cell_vol_ff};
         end
         4'd6, 4'd7, 4'd8: begin
            op_a   = mag(item_ff.area[2'(step_ff - 4'd6)]);
            op_b   = mag(item_ff.offset[2'(step_ff - 4'd6)]);
            op_neg = item_ff.area[2'(step_ff - 4'd6)][63]
                     ^ item_ff.offset[2'(step_ff - 4'd6)][63];
         end
         4'd9: begin
            op_a   = {1'b0, light_ff};
            op_b   = mag(adot_ff);
            op_neg = adot_ff[63];
         end
         4'd10: begin
            op_a   = mag(num_ff);
            op_b   = mag(de_res[63:0]);
            op_neg = num_ff[63] ^ de_res[63];
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   always_comb begin
      prod_mag = mul_rsp.prod[FRAC_BITS +: 64];
      prod_hi  = mul_rsp.prod[127:FRAC_BITS+64];
      lim      = neg_ff ? MIN64 : MAX63;
      over     = (|prod_hi) || (prod_mag > lim);
      sat_val  = over ? lim : prod_mag;
      res      = neg_ff ? (~sat_val + 64'd1) : sat_val;
      sum_f    = {1'b0, cell_cs_ff} + {1'b0, res[62:0]};
      sig_f    = sum_f[63:1];
      add_res  = '0;
      t_in     = t_ff;
      den_in   = den_ff;
      adot_in  = adot_ff;
      num_in   = num_ff;
      wb_err   = over;
      unique case (step_ff)
         4'd0: begin
            if (sig_f > SIGF_MAX) begin
               wb_err = 1'b1;
               den_in = MAX63;
            end else begin
               den_in = {sig_f, 1'b0} + {1'b0, sig_f};
            end
         end
         4'd1: t_in = res;
         4'd2, 4'd3: begin
            add_res = {1'b0, t_ff} + {1'b0, res};
            if (add_res[63:0] > MAX63) begin
               wb_err = 1'b1;
               t_in   = MAX63;
            end else begin
               t_in = add_res[63:0];
            end
         end
         4'd4, 4'd5: den_in = res;
         4'd6: adot_in = res;
         4'd7, 4'd8: begin
            add_res = sadd(adot_ff, res);
            adot_in = add_res[63:0];
            wb_err  = over | add_res[64];
         end
         4'd9, 4'd10: num_in = res;
         default: begin
            wb_err = over;
         end
      endcase
      acc_sum = sadd(acc_ff, div_rsp.quot);
   end

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign mul_req    = mul_req_ff;
   assign div_req    = div_req_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_err    = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cell_cs_ff       <= '0;
         cell_vol_ff      <= '0;
         cell_en_ff       <= '0;
         acc_ff           <= '0;
         err_seen_ff      <= 1'b0;
         light_ff         <= LIGHT_RESET;
         step_ff          <= 4'd0;
         err_ff           <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wen) begin
            light_ff <= csr_wdata;
         end
         mul_req_ff.start <= (state_ff == ST_ISSUE);
         div_req_ff.start <= (state_ff == ST_DIV_ISSUE) && (den_ff != 64'd0);
         if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff <= q_item;
                  unique case (q_item.kind)
                     KIND_HEADER: begin
                        cell_cs_ff  <= q_item.qa;
                        cell_vol_ff <= q_item.qb;
                        cell_en_ff  <= q_item.energy;
                        acc_ff      <= '0;
                        err_seen_ff <= 1'b0;
                     end
                     KIND_FACE: begin
                        step_ff  <= 4'd0;
                        err_ff   <= 1'b0;
                        state_ff <= ST_ISSUE;
                     end
                     KIND_REFLECT: begin
                        if (q_item.last) begin
                           state_ff <= ST_EMIT;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_ISSUE: begin
               mul_req_ff.a <= op_a;
               mul_req_ff.b <= op_b;
               neg_ff       <= op_neg;
               if ((step_ff == LAST_STEP) && de_res[64]) begin
                  err_ff <= 1'b1;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (mul_rsp.done) begin
                  t_ff    <= t_in;
                  den_ff  <= den_in;
                  adot_ff <= adot_in;
                  num_ff  <= num_in;
                  if (wb_err) begin
                     err_ff <= 1'b1;
                  end
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= (step_ff == LAST_STEP) ? ST_DIV_ISSUE : ST_ISSUE;
               end
            end
            ST_DIV_ISSUE: begin
               if (den_ff == 64'd0) begin
                  err_ff   <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  div_req_ff.num <= num_ff;
                  div_req_ff.den <= den_ff;
                  state_ff       <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  acc_ff <= acc_sum[63:0];
                  if (div_rsp.err || acc_sum[64]) begin
                     err_ff <= 1'b1;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               err_seen_ff <= err_seen_ff | err_ff;
               state_ff    <= item_ff.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= acc_ff;
                  rsp_err_ff   <= err_seen_ff;
                  acc_ff       <= '0;
                  err_seen_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
